// File: rtl/core/sfb_pkg.sv
// Shared types and constants for the sequenced frame builder.
package sfb_pkg;

    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_VERSION  = 2'd0;
    localparam cfg_idx_t CFG_MAC_EN   = 2'd1;
    localparam cfg_idx_t CFG_MAC_ADDR = 2'd2;

    localparam logic [7:0] SYNC0_BYTE = 8'h66;
    localparam logic [7:0] SYNC1_BYTE = 8'hFF;
    localparam logic [7:0] ACK_BYTE   = 8'h00;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic KIND_START = 1'b0;

    // byte position within one word's result run
    typedef logic [4:0] step_t;

    localparam step_t ST_SYNC0  = 5'd0;
    localparam step_t ST_SYNC1  = 5'd1;
    localparam step_t ST_VER    = 5'd2;
    localparam step_t ST_MAC0   = 5'd3;
    localparam step_t ST_MAC5   = 5'd8;
    localparam step_t ST_SEQ0   = 5'd9;
    localparam step_t ST_SEQ3   = 5'd12;
    localparam step_t ST_ACK    = 5'd13;
    localparam step_t ST_LEN    = 5'd14;
    localparam step_t ST_CMD    = 5'd15;
    localparam step_t ST_CRC_HI = 5'd16;
    localparam step_t ST_CRC_LO = 5'd17;
    localparam step_t ST_DATA   = 5'd18;

    typedef enum logic [2:0] {
        MODE_START = 3'b001,
        MODE_DATA  = 3'b010,
        MODE_DROP  = 3'b100
    } mode_t;

    typedef struct packed {
        logic       init;
        logic       feed;
        logic [7:0] data;
    } crc_ctl_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       run_end;
        logic       error_flag;
    } res_t;

endpackage

// File: rtl/core/sfb_crc.sv
// Modbus CRC-16 register, one byte folded in per cycle while feed is set.
module sfb_crc
    import sfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  crc_ctl_t    ctl,
    output logic [15:0] crc_value
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (v[0])
                v = (v >> 1) ^ CRC_POLY;
            else
                v = v >> 1;
        end
        return v;
    endfunction

    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.init)
            crc_next = CRC_INIT;
        else if (ctl.feed)
            crc_next = crc_byte(crc_reg, ctl.data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

    assign crc_value = crc_reg;

endmodule

// File: rtl/core/sfb_ctrl.sv
// Frame state, held word and byte sequencer for the frame builder.
module sfb_ctrl
    import sfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  command,
    input  logic [7:0]  payload_length,
    input  logic        is_resend,
    input  logic [31:0] resend_sequence,
    input  logic [7:0]  payload_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_idx_t    cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        out_free,
    output logic        res_load,
    output res_t        res,
    output logic [31:0] seq_used,
    output crc_ctl_t    crc_ctl,
    input  logic [15:0] crc_value
);

    logic [7:0]  version_reg;
    logic        mac_en_reg;
    logic [47:0] mac_reg;

    logic [31:0] seq_cnt_reg;
    logic [31:0] cur_seq_reg;
    logic [7:0]  rem_reg;
    logic        open_reg;

    logic        busy_reg;
    logic        busy_next;
    mode_t       mode_reg;
    step_t       step_reg;
    step_t       step_next;
    logic        err_reg;
    logic        close_reg;
    logic [7:0]  cmd_reg;
    logic [7:0]  len_reg;
    logic [7:0]  pb_reg;

    logic        in_fire;
    logic        last;
    logic        feed_byte;
    step_t       mac_off;
    step_t       seq_off;
    logic [31:0] seq_inc;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign res_load  = busy_reg && out_free;
    assign in_ready  = !busy_reg || (res_load && last);
    assign seq_used  = cur_seq_reg;
    assign mac_off   = step_reg - ST_MAC0;
    assign seq_off   = step_reg - ST_SEQ0;
    assign seq_inc   = seq_cnt_reg + 32'd1;

    always_comb
    begin
        case (mode_reg)
            MODE_START: last = (step_reg == ST_CMD && !close_reg) || step_reg == ST_CRC_LO;
            MODE_DATA:  last = (step_reg == ST_DATA && !close_reg) || step_reg == ST_CRC_LO;
            MODE_DROP:  last = 1'b1;
            default:    last = 1'b1;
        endcase
    end

    always_comb
    begin
        if (step_reg == ST_VER)
            step_next = mac_en_reg ? ST_MAC0 : ST_SEQ0;
        else if (step_reg == ST_CMD || step_reg == ST_DATA)
            step_next = ST_CRC_HI;
        else
            step_next = step_reg + 5'd1;
    end

    always_comb
    begin
        res            = '0;
        res.run_end    = last;
        res.error_flag = err_reg;
        res.byte_valid = 1'b1;
        feed_byte      = 1'b1;
        case (step_reg) inside
            ST_SYNC0:            res.out_byte = SYNC0_BYTE;
            ST_SYNC1:            res.out_byte = SYNC1_BYTE;
            ST_VER:              res.out_byte = version_reg;
            [ST_MAC0:ST_MAC5]:   res.out_byte = mac_reg[{mac_off[2:0], 3'b000} +: 8];
            [ST_SEQ0:ST_SEQ3]:   res.out_byte = cur_seq_reg[{seq_off[1:0], 3'b000} +: 8];
            ST_ACK:              res.out_byte = ACK_BYTE;
            ST_LEN:              res.out_byte = len_reg;
            ST_CMD:              res.out_byte = cmd_reg;
            ST_CRC_HI:
            begin
                // wire order: low byte of the CRC value first
                res.out_byte = crc_value[7:0];
                feed_byte    = 1'b0;
            end
            ST_CRC_LO:
            begin
                res.out_byte  = crc_value[15:8];
                res.frame_end = 1'b1;
                feed_byte     = 1'b0;
            end
            ST_DATA:
            begin
                if (mode_reg == MODE_DATA)
                    res.out_byte = pb_reg;
                else
                begin
                    res.byte_valid = 1'b0;
                    feed_byte      = 1'b0;
                end
            end
            default:
            begin
                res.byte_valid = 1'b0;
                feed_byte      = 1'b0;
            end
        endcase
    end

    // a start word resets the CRC over any byte folded in the same cycle
    assign crc_ctl.init = in_fire && kind == KIND_START;
    assign crc_ctl.feed = res_load && feed_byte;
    assign crc_ctl.data = res.out_byte;

    always_comb
    begin
        busy_next = busy_reg;
        if (in_fire)
            busy_next = 1'b1;
        else if (res_load && last)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= 8'h00;
            mac_en_reg  <= 1'b1;
            mac_reg     <= 48'h0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_VERSION:  version_reg <= cfg_data[7:0];
                CFG_MAC_EN:   mac_en_reg  <= cfg_data[0];
                CFG_MAC_ADDR: mac_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            mode_reg    <= MODE_DROP;
            step_reg    <= ST_DATA;
            err_reg     <= 1'b0;
            close_reg   <= 1'b0;
            seq_cnt_reg <= 32'h0;
            cur_seq_reg <= 32'h0;
            rem_reg     <= 8'h00;
            open_reg    <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (in_fire)
            begin
                if (kind == KIND_START)
                begin
                    mode_reg  <= MODE_START;
                    step_reg  <= ST_SYNC0;
                    err_reg   <= open_reg;
                    close_reg <= payload_length == 8'h00;
                    open_reg  <= payload_length != 8'h00;
                    rem_reg   <= payload_length;
                    if (is_resend)
                        cur_seq_reg <= resend_sequence;
                    else
                    begin
                        seq_cnt_reg <= seq_inc;
                        cur_seq_reg <= seq_inc;
                    end
                end
                else if (open_reg)
                begin
                    mode_reg  <= MODE_DATA;
                    step_reg  <= ST_DATA;
                    err_reg   <= 1'b0;
                    close_reg <= rem_reg == 8'd1;
                    open_reg  <= rem_reg != 8'd1;
                    rem_reg   <= rem_reg - 8'd1;
                end
                else
                begin
                    mode_reg  <= MODE_DROP;
                    step_reg  <= ST_DATA;
                    err_reg   <= 1'b1;
                    close_reg <= 1'b0;
                end
            end
            else if (res_load)
                step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= command;
            len_reg <= payload_length;
            pb_reg  <= payload_byte;
        end
    end

    a_fend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && res.frame_end |-> res.run_end)
        else $error("frame end not on last result of word");

    a_ready_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && in_ready |-> res_load && last)
        else $error("word taken while previous word still emitting");

    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> rem_reg != 8'h00)
        else $error("open frame with no payload bytes left");

    a_feed_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        crc_ctl.feed |-> busy_reg && res.byte_valid)
        else $error("CRC fed without an emitted byte");

endmodule

// File: rtl/core/sequenced_frame_builder_crc16_unit.sv
// Top level of the sequenced frame builder: sequencer, CRC and output register.
// A taken word first sets the sequencer registers; its results then load the output register.
// Throughput: one result per cycle unless the output stalls; a payload word gives 1 result,
// 3 when it closes the frame, and a start word 10 to 18, set by address enable and length.
// Reset: frame closed, counters zero, CRC 0xFFFF, version 0, address enabled and zero.
module sequenced_frame_builder_crc16_unit
    import sfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  command,
    input  logic [7:0]  payload_length,
    input  logic        is_resend,
    input  logic [31:0] resend_sequence,
    input  logic [7:0]  payload_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        frame_end,
    output logic        run_end,
    output logic [31:0] sequence_used,
    output logic        error_flag,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_idx_t    cfg_index,
    input  logic [47:0] cfg_data
);

    logic        out_valid_reg;
    res_t        res_reg;
    logic [31:0] seq_reg;

    logic        out_free;
    logic        res_load;
    res_t        res;
    logic [31:0] seq_used;
    crc_ctl_t    crc_ctl;
    logic [15:0] crc_value;

    assign out_free = !out_valid_reg || out_ready;

    sfb_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .command         (command),
        .payload_length  (payload_length),
        .is_resend       (is_resend),
        .resend_sequence (resend_sequence),
        .payload_byte    (payload_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_free        (out_free),
        .res_load        (res_load),
        .res             (res),
        .seq_used        (seq_used),
        .crc_ctl         (crc_ctl),
        .crc_value       (crc_value)
    );

    sfb_crc u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (crc_ctl),
        .crc_value (crc_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
            seq_reg <= seq_used;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = res_reg.out_byte;
    assign byte_valid    = res_reg.byte_valid;
    assign frame_end     = res_reg.frame_end;
    assign run_end       = res_reg.run_end;
    assign error_flag    = res_reg.error_flag;
    assign sequence_used = seq_reg;

endmodule
